### rtl/ipfrt_pkg.sv
// Package with the shared types and constants of the fragment reassembly tracker.
`default_nettype none
package ipfrt_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_DROPPED = 2'd0;
   localparam logic [1:0] KIND_STORED  = 2'd1;
   localparam logic [1:0] KIND_PIECE   = 2'd2;

   // Register index of the lifetime register.
   localparam logic REG_LIFETIME = 1'b0;
   localparam logic [7:0] LIFETIME_RESET = 8'd30;

   // Width of the running byte offset while a chain is followed.
   localparam int NEXT_W = 24;

   // One descriptor table entry as held in the table memory.
   typedef struct packed {
      logic [15:0] ident;
      logic [12:0] offset_units;
      logic [15:0] length;
      logic        more;
      logic [31:0] expiry;
   } entry_type;

endpackage
`default_nettype wire

### rtl/ipfrt_req_if.sv
// Input channel interface: one fragment descriptor per transfer.
`default_nettype none
interface ipfrt_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_seconds;
   logic [15:0] frag_ident;
   logic [12:0] frag_offset_units;
   logic        more_fragments;
   logic [15:0] total_length;
   logic [3:0]  header_words;

   modport source (output valid, now_seconds, frag_ident, frag_offset_units,
                   more_fragments, total_length, header_words, input ready);
   modport sink (input valid, now_seconds, frag_ident, frag_offset_units,
                 more_fragments, total_length, header_words, output ready);
endinterface
`default_nettype wire

### rtl/ipfrt_rsp_if.sv
// Result channel interface: one result item per transfer.
`default_nettype none
interface ipfrt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [3:0]  slot;
   logic [15:0] ident;
   logic [15:0] piece_offset;
   logic [15:0] piece_length;
   logic        last;

   modport source (output valid, result_kind, slot, ident, piece_offset, piece_length,
                   last, input ready);
   modport sink (input valid, result_kind, slot, ident, piece_offset, piece_length,
                 last, output ready);
endinterface
`default_nettype wire

### rtl/ipfrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ipfrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### rtl/ip_fragment_reassembly_tracker.sv
// Top level of the IPv4 fragment reassembly tracker.
`default_nettype none
// Each input transfer describes one arriving fragment. The block works on one
// fragment at a time and takes the next once the results of the current one are
// in the output register. On a new second it sweeps the table memory for expired
// entries, one read per cycle. The fragment is then stored, or dropped when no slot
// is free. The chain of the fragment's ident is then followed from offset zero:
// each round is one parallel compare over the tag registers plus one table read
// (up to SLOTS rounds, and a final compare when the chain stays open). A closed
// chain is emitted piece by piece, each piece read from the table memory and then
// loaded into the output register. A stall on the result side holds the block.
// Entries are freed through per-slot valid bits cleared at reset.
module ip_fragment_reassembly_tracker #(
   parameter int SLOTS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   ipfrt_req_if.sink         req_ch,
   ipfrt_rsp_if.source       rsp_ch,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [2:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic      [31:0]  prdata,
   output logic              pready
);
   localparam int SW = $clog2(SLOTS);
   localparam int NW = ipfrt_pkg::NEXT_W;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SWEEP   = 3'd1;
   localparam logic [2:0] ST_ALLOC   = 3'd2;
   localparam logic [2:0] ST_SEARCH  = 3'd3;
   localparam logic [2:0] ST_STEP    = 3'd4;
   localparam logic [2:0] ST_EMIT_RD = 3'd5;
   localparam logic [2:0] ST_EMIT_LD = 3'd6;
   localparam logic [2:0] ST_OUT     = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [7:0]  life_ff, life_in;
   logic [31:0] last_sweep_ff, last_sweep_in;

   // Latched fragment.
   logic [31:0] now_ff, now_in;
   logic [15:0] ident_ff, ident_in;
   logic [12:0] offu_ff, offu_in;
   logic        more_ff, more_in;
   logic [15:0] len_ff, len_in;
   logic [31:0] expiry_ff, expiry_in;

   // Table bookkeeping.
   logic [SLOTS-1:0]         valid_ff, valid_in;
   logic [SLOTS-1:0]         used_ff, used_in;
   logic [SLOTS-1:0][15:0]   tag_ident_ff, tag_ident_in;
   logic [SLOTS-1:0][12:0]   tag_off_ff, tag_off_in;
   logic [SLOTS-1:0][SW-1:0] chain_ff, chain_in;
   logic [SW:0]              cnt_ff, cnt_in;
   logic                     chk_ff, chk_in;
   logic [SW-1:0]            chk_idx_ff, chk_idx_in;
   logic [SW:0]              n_ff, n_in;
   logic [SW:0]              emit_ff, emit_in;
   logic [NW-1:0]            next_ff, next_in;
   logic [SW-1:0]            alloc_ff, alloc_in;
   logic [1:0]               pend_kind_ff, pend_kind_in;

   // Output register.
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [3:0]  out_slot_ff, out_slot_in;
   logic [15:0] out_ident_ff, out_ident_in;
   logic [15:0] out_off_ff, out_off_in;
   logic [15:0] out_len_ff, out_len_in;
   logic        out_last_ff, out_last_in;

   // Memory ports.
   logic                    wr_en, rd_en;
   logic [SW-1:0]           wr_addr, rd_addr;
   ipfrt_pkg::entry_type    wr_data, rd_data;

   // Combinational helpers.
   logic                 accept;
   logic                 out_free;
   logic [5:0]           hdr_bytes;
   logic [32:0]          exp_sum;
   logic                 free_any;
   logic [SW-1:0]        free_idx;
   logic [SLOTS-1:0]     hit_vec;
   logic                 hit_any;
   logic [SW-1:0]        hit_idx;
   logic                 cfg_write;

   ipfrt_ram #(
      .WIDTH($bits(ipfrt_pkg::entry_type)),
      .DEPTH(SLOTS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Handshake and configuration port.
   assign accept          = req_ch.valid && req_ch.ready;
   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign out_free        = !out_valid_ff || rsp_ch.ready;
   assign pready          = 1'b1;
   assign cfg_write       = psel && penable && pwrite && (paddr[2] == ipfrt_pkg::REG_LIFETIME);
   assign prdata          = (paddr[2] == ipfrt_pkg::REG_LIFETIME) ? {24'd0, life_ff} : 32'd0;

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.result_kind  = out_kind_ff;
   assign rsp_ch.slot         = out_slot_ff;
   assign rsp_ch.ident        = out_ident_ff;
   assign rsp_ch.piece_offset = out_off_ff;
   assign rsp_ch.piece_length = out_len_ff;
   assign rsp_ch.last         = out_last_ff;

   // Header length in bytes and expiry sum (saturated when latched) of the arriving fragment.
   assign hdr_bytes = {req_ch.header_words, 2'b00};
   assign exp_sum   = {1'b0, req_ch.now_seconds} + {25'd0, life_ff};

   // Lowest free slot and lowest matching chain candidate.
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      hit_any  = 1'b0;
      hit_idx  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         hit_vec[i] = valid_ff[i] && !used_ff[i] && (tag_ident_ff[i] == ident_ff) &&
                      ({{(NW-16){1'b0}}, tag_off_ff[i], 3'b000} == next_ff);
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = SW'(i);
         end
         if (hit_vec[i]) begin
            hit_any = 1'b1;
            hit_idx = SW'(i);
         end
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      life_in       = cfg_write ? pwdata[7:0] : life_ff;
      last_sweep_in = last_sweep_ff;
      now_in        = now_ff;
      ident_in      = ident_ff;
      offu_in       = offu_ff;
      more_in       = more_ff;
      len_in        = len_ff;
      expiry_in     = expiry_ff;
      valid_in      = valid_ff;
      used_in       = used_ff;
      tag_ident_in  = tag_ident_ff;
      tag_off_in    = tag_off_ff;
      chain_in      = chain_ff;
      cnt_in        = cnt_ff;
      chk_in        = 1'b0;
      chk_idx_in    = chk_idx_ff;
      n_in          = n_ff;
      emit_in       = emit_ff;
      next_in       = next_ff;
      alloc_in      = alloc_ff;
      pend_kind_in  = pend_kind_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_kind_in   = out_kind_ff;
      out_slot_in   = out_slot_ff;
      out_ident_in  = out_ident_ff;
      out_off_in    = out_off_ff;
      out_len_in    = out_len_ff;
      out_last_in   = out_last_ff;
      wr_en         = 1'b0;
      wr_addr       = free_idx;
      wr_data       = '{ident: ident_ff, offset_units: offu_ff, length: len_ff,
                        more: more_ff, expiry: expiry_ff};
      rd_en         = 1'b0;
      rd_addr       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               now_in    = req_ch.now_seconds;
               ident_in  = req_ch.frag_ident;
               offu_in   = req_ch.frag_offset_units;
               more_in   = req_ch.more_fragments;
               len_in    = (req_ch.total_length > {10'd0, hdr_bytes}) ?
                           req_ch.total_length - {10'd0, hdr_bytes} : 16'd0;
               expiry_in = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
               cnt_in    = '0;
               if (last_sweep_ff < req_ch.now_seconds) begin
                  last_sweep_in = req_ch.now_seconds;
                  state_in      = ST_SWEEP;
               end else begin
                  state_in = ST_ALLOC;
               end
            end
         end
         // One read issued per cycle; the entry read in the cycle before is checked.
         ST_SWEEP: begin
            if (chk_ff && valid_ff[chk_idx_ff] && (rd_data.expiry <= now_ff)) begin
               valid_in[chk_idx_ff] = 1'b0;
            end
            if (cnt_ff < (SW+1)'(SLOTS)) begin
               rd_en      = 1'b1;
               rd_addr    = cnt_ff[SW-1:0];
               chk_in     = 1'b1;
               chk_idx_in = cnt_ff[SW-1:0];
               cnt_in     = cnt_ff + 1'b1;
            end else begin
               state_in = ST_ALLOC;
            end
         end
         ST_ALLOC: begin
            if (!free_any) begin
               pend_kind_in = ipfrt_pkg::KIND_DROPPED;
               alloc_in     = '0;
               state_in     = ST_OUT;
            end else begin
               wr_en                  = 1'b1;
               valid_in[free_idx]     = 1'b1;
               tag_ident_in[free_idx] = ident_ff;
               tag_off_in[free_idx]   = offu_ff;
               alloc_in               = free_idx;
               used_in                = '0;
               next_in                = '0;
               n_in                   = '0;
               state_in               = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (!hit_any) begin
               pend_kind_in = ipfrt_pkg::KIND_STORED;
               state_in     = ST_OUT;
            end else begin
               used_in[hit_idx]       = 1'b1;
               chain_in[n_ff[SW-1:0]] = hit_idx;
               n_in                   = n_ff + 1'b1;
               rd_en                  = 1'b1;
               rd_addr                = hit_idx;
               state_in               = ST_STEP;
            end
         end
         ST_STEP: begin
            next_in = next_ff + {{(NW-16){1'b0}}, rd_data.length};
            if (!rd_data.more) begin
               emit_in  = '0;
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_EMIT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = chain_ff[emit_ff[SW-1:0]];
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = ipfrt_pkg::KIND_PIECE;
               out_slot_in  = 4'(chain_ff[emit_ff[SW-1:0]]);
               out_ident_in = rd_data.ident;
               out_off_in   = {rd_data.offset_units, 3'b000};
               out_len_in   = rd_data.length;
               out_last_in  = (emit_ff == n_ff - 1'b1);
               valid_in[chain_ff[emit_ff[SW-1:0]]] = 1'b0;
               emit_in      = emit_ff + 1'b1;
               state_in     = (emit_ff == n_ff - 1'b1) ? ST_IDLE : ST_EMIT_RD;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = pend_kind_ff;
               out_slot_in  = 4'(alloc_ff);
               out_ident_in = ident_ff;
               out_off_in   = {offu_ff, 3'b000};
               out_len_in   = len_ff;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         life_ff       <= ipfrt_pkg::LIFETIME_RESET;
         last_sweep_ff <= '0;
         valid_ff      <= '0;
         chk_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         life_ff       <= life_in;
         last_sweep_ff <= last_sweep_in;
         valid_ff      <= valid_in;
         chk_ff        <= chk_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      ident_ff     <= ident_in;
      offu_ff      <= offu_in;
      more_ff      <= more_in;
      len_ff       <= len_in;
      expiry_ff    <= expiry_in;
      used_ff      <= used_in;
      tag_ident_ff <= tag_ident_in;
      tag_off_ff   <= tag_off_in;
      chain_ff     <= chain_in;
      cnt_ff       <= cnt_in;
      chk_idx_ff   <= chk_idx_in;
      n_ff         <= n_in;
      emit_ff      <= emit_in;
      next_ff      <= next_in;
      alloc_ff     <= alloc_in;
      pend_kind_ff <= pend_kind_in;
      out_kind_ff  <= out_kind_in;
      out_slot_ff  <= out_slot_in;
      out_ident_ff <= out_ident_in;
      out_off_ff   <= out_off_in;
      out_len_ff   <= out_len_in;
      out_last_ff  <= out_last_in;
   end
endmodule
`default_nettype wire

### rtl/ipfrt_checker.sv
// Port-level checker for the fragment reassembly tracker, with its bind statement.
`default_nettype none
module ipfrt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_kind,
   input wire logic [3:0]  rsp_slot,
   input wire logic        rsp_last,
   input wire logic [15:0] rsp_offset
);
   // A stalled result keeps its contents.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_slot)
         && $stable(rsp_last) && $stable(rsp_offset))
      else $error("result changed while stalled");

   // Only the three defined kinds ever appear.
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind == ipfrt_pkg::KIND_DROPPED || rsp_kind == ipfrt_pkg::KIND_STORED
         || rsp_kind == ipfrt_pkg::KIND_PIECE)
      else $error("undefined result kind");

   // A drop is a single result on slot zero.
   a_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == ipfrt_pkg::KIND_DROPPED |-> rsp_last && rsp_slot == 4'd0)
      else $error("malformed drop result");

   // A stored fragment is always the only result of its item.
   a_stored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == ipfrt_pkg::KIND_STORED |-> rsp_last)
      else $error("stored result without last");
endmodule

bind ip_fragment_reassembly_tracker ipfrt_checker u_ipfrt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_kind  (rsp_ch.result_kind),
   .rsp_slot  (rsp_ch.slot),
   .rsp_last  (rsp_ch.last),
   .rsp_offset(rsp_ch.piece_offset)
);
`default_nettype wire
